// ----- hw/rtl/mf3_pkg.sv -----
// Shared types, constants and compare helpers for the 3x3 median filter.
// Used by every module of the block but mf3_ram; depends on nothing else.
package mf3_pkg;

  // Geometry of the line stores and the pixel word.
  localparam int unsigned MaxWidth  = 2048;
  localparam int unsigned PixelBits = 8;
  localparam int unsigned ColW      = $clog2(MaxWidth);
  localparam int unsigned CfgW      = 12;
  localparam int unsigned RowW      = 12;

  // Frame size limits and reset values of the configuration registers.
  localparam logic [CfgW-1:0] WidthReset  = CfgW'(640);
  localparam logic [CfgW-1:0] HeightReset = CfgW'(480);
  localparam logic [CfgW-1:0] MinDim      = CfgW'(3);
  localparam logic [CfgW-1:0] MaxDim      = CfgW'(MaxWidth);

  // The first two rows and columns of a frame are border pixels.
  localparam logic [ColW-1:0] FirstInnerCol = ColW'(2);
  localparam logic [RowW-1:0] FirstInnerRow = RowW'(2);

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef logic [PixelBits-1:0] pixel_t;

  // One full 3x3 neighborhood, grouped as three triples of three pixels.
  typedef struct packed {
    pixel_t [8:0] pix;
    logic         last;
  } window_t;

  function automatic pixel_t pix_min(input pixel_t a, input pixel_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pixel_t pix_max(input pixel_t a, input pixel_t b);
    return (a < b) ? b : a;
  endfunction

  // Median of three values.
  function automatic pixel_t med3(input pixel_t a, input pixel_t b, input pixel_t c);
    return pix_max(pix_min(a, b), pix_min(pix_max(a, b), c));
  endfunction

endpackage

// ----- hw/rtl/median_filter_3x3.sv -----
// Top level of the 3x3 median filter: configuration registers and the two stages.
// Depends on mf3_pkg, mf3_window, mf3_median and mf3_ram.
//
// Usage:
// - Input channel: one 8-bit pixel word per handshake (in_valid_i, in_stall_o,
//   pixel_i), raster order, row by row.
// - Output channel: one word per interior pixel (out_valid_o, out_stall_i,
//   median_value_o, last_of_frame_o). The first two rows and the first two
//   columns of each frame produce no word. last_of_frame_o marks the word
//   caused by the final pixel of the frame.
// - Configuration: cfg_we_i writes cfg_data_i to the register at cfg_index_i
//   (frame width, frame height); write only while idle.
// - Path: read stage, window register, stages A and B, then output register.
// - Throughput: one pixel per cycle unless stalled, set by one read and one write
//   of each line store per pixel; the compare network is fully pipelined.
// - Reset: counters restart at row 0, column 0, pipeline emptied, width 640,
//   height 480. The line stores are not cleared.
// - Stall: a stalled output holds its word while the pipeline keeps filling
//   its empty stages; in_stall_o rises only once every stage is occupied.
module median_filter_3x3 (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  mf3_pkg::pixel_t          pixel_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output mf3_pkg::pixel_t          median_value_o,
  output logic                     last_of_frame_o,
  input  logic                     cfg_we_i,
  input  logic [0:0]               cfg_index_i,
  input  logic [mf3_pkg::CfgW-1:0] cfg_data_i
);

  logic [mf3_pkg::CfgW-1:0] frame_width_q, frame_height_q;
  logic                     win_valid, win_ready;
  mf3_pkg::window_t         win;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= mf3_pkg::WidthReset;
      frame_height_q <= mf3_pkg::HeightReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        mf3_pkg::CFG_WIDTH:  frame_width_q  <= cfg_data_i;
        mf3_pkg::CFG_HEIGHT: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Line stores and window.
  mf3_window u_window (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .valid_i        (in_valid_i),
    .stall_o        (in_stall_o),
    .pixel_i        (pixel_i),
    .win_valid_o    (win_valid),
    .win_ready_i    (win_ready),
    .win_o          (win)
  );

  // Median network and output register.
  mf3_median u_median (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .win_valid_i     (win_valid),
    .win_ready_o     (win_ready),
    .win_i           (win),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .median_value_o  (median_value_o),
    .last_of_frame_o (last_of_frame_o)
  );

`ifndef SYNTH
  // The input stalls only when the window stage is blocked by the median network.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (win_valid && !win_ready))
    else $error("input stalled while the window stage could move");

  // The median network backs up only behind a stalled output word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !win_ready |-> (out_valid_o && out_stall_i))
    else $error("median network blocked without a stalled output");

  // A blocked window word is kept intact for the median network.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (win_valid && !win_ready) |=> (win_valid && $stable(win)))
    else $error("window word lost or changed while blocked");
`endif

endmodule

// ----- hw/rtl/mf3_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read port.
// Stand-alone; no package needed.
module mf3_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/mf3_window.sv -----
// Raster counters, the two line stores and the 3x3 window register.
// Depends on mf3_pkg and mf3_ram.
module mf3_window (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [mf3_pkg::CfgW-1:0]      frame_width_i,
  input  logic [mf3_pkg::CfgW-1:0]      frame_height_i,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  mf3_pkg::pixel_t               pixel_i,
  output logic                          win_valid_o,
  input  logic                          win_ready_i,
  output mf3_pkg::window_t              win_o
);

  // Raster position of the next pixel.
  logic [mf3_pkg::ColW-1:0] col_q, col_d;
  logic [mf3_pkg::RowW-1:0] row_q, row_d;

  // Read stage: the pixel waits here for the line store data.
  logic                     s1_valid_q;
  mf3_pkg::pixel_t          s1_pix_q;
  logic [mf3_pkg::ColW-1:0] s1_col_q;
  logic                     s1_emit_q;
  logic                     s1_last_q;

  // The two previous columns of the neighborhood (top, middle, bottom each).
  mf3_pkg::pixel_t [5:0]    wcol_q;

  logic                     win_valid_q;
  mf3_pkg::window_t         win_q;

  logic                     ready1, ready2, accept, adv1;
  logic [mf3_pkg::CfgW-1:0] eff_w, eff_h, col_inc;
  logic [mf3_pkg::RowW:0]   row_inc;
  logic                     row_end, frame_end, emit;
  mf3_pkg::pixel_t          top_rd, mid_rd;

  // Handshake chain: each stage moves when the one after it has room.
  assign ready2  = !win_valid_q || win_ready_i;
  assign ready1  = !s1_valid_q || ready2;
  assign adv1    = s1_valid_q && ready2;
  assign accept  = valid_i && ready1;
  assign stall_o = !ready1;

  // Clamp the width to the line store depth and both sizes to at least three.
  always_comb begin
    if (frame_width_i < mf3_pkg::MinDim) begin
      eff_w = mf3_pkg::MinDim;
    end else if (frame_width_i > mf3_pkg::MaxDim) begin
      eff_w = mf3_pkg::MaxDim;
    end else begin
      eff_w = frame_width_i;
    end
    eff_h = (frame_height_i < mf3_pkg::MinDim) ? mf3_pkg::MinDim : frame_height_i;
  end

  // Row and frame boundaries for the word being accepted.
  assign col_inc   = mf3_pkg::CfgW'(col_q) + mf3_pkg::CfgW'(1);
  assign row_inc   = {1'b0, row_q} + (mf3_pkg::RowW+1)'(1);
  assign row_end   = col_inc >= eff_w;
  assign frame_end = row_end && (row_inc >= {1'b0, eff_h});
  assign emit      = (row_q >= mf3_pkg::FirstInnerRow) && (col_q >= mf3_pkg::FirstInnerCol);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (row_end) begin
        col_d = '0;
        row_d = frame_end ? '0 : row_inc[mf3_pkg::RowW-1:0];
      end else begin
        col_d = col_inc[mf3_pkg::ColW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Line stores: read on accept, write back when the word leaves the read
  // stage. Consecutive words always hit different columns.
  mf3_ram #(
    .Width(mf3_pkg::PixelBits),
    .Depth(mf3_pkg::MaxWidth)
  ) u_upper (
    .clk_i   (clk_i),
    .we_i    (adv1),
    .waddr_i (s1_col_q),
    .wdata_i (mid_rd),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (top_rd)
  );

  mf3_ram #(
    .Width(mf3_pkg::PixelBits),
    .Depth(mf3_pkg::MaxWidth)
  ) u_middle (
    .clk_i   (clk_i),
    .we_i    (adv1),
    .waddr_i (s1_col_q),
    .wdata_i (s1_pix_q),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (mid_rd)
  );

  // Read stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (ready1) begin
      s1_valid_q <= accept;
    end
  end

  // Read stage payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q  <= pixel_i;
      s1_col_q  <= col_q;
      s1_emit_q <= emit;
      s1_last_q <= frame_end;
    end
  end

  // Window shift: every word moves the window, emitted or not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wcol_q <= '0;
    end else if (adv1) begin
      wcol_q <= {s1_pix_q, mid_rd, top_rd, wcol_q[5:3]};
    end
  end

  // Window output register; only interior pixels pass on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_valid_q <= 1'b0;
    end else if (ready2) begin
      win_valid_q <= adv1 && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      win_q.pix  <= {s1_pix_q, wcol_q[5], wcol_q[2],
                     mid_rd,   wcol_q[4], wcol_q[1],
                     top_rd,   wcol_q[3], wcol_q[0]};
      win_q.last <= s1_last_q;
    end
  end

  assign win_valid_o = win_valid_q;
  assign win_o       = win_q;

endmodule

// ----- hw/rtl/mf3_median.sv -----
// Three-stage median-of-nine compare network ending in the output register.
// Depends on mf3_pkg.
module mf3_median (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             win_valid_i,
  output logic             win_ready_o,
  input  mf3_pkg::window_t win_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output mf3_pkg::pixel_t  median_value_o,
  output logic             last_of_frame_o
);

  // Stage A: each triple sorted into low, middle and high.
  logic                  a_valid_q;
  mf3_pkg::pixel_t [2:0] a_lo_q, a_md_q, a_hi_q;
  logic                  a_last_q;
  mf3_pkg::pixel_t [2:0] a_lo_d, a_md_d, a_hi_d;

  // Stage B: largest low, median of middles, smallest high.
  logic                  b_valid_q;
  mf3_pkg::pixel_t       b_lo_q, b_md_q, b_hi_q;
  logic                  b_last_q;

  // Output register.
  logic                  out_valid_q;
  mf3_pkg::pixel_t       out_med_q;
  logic                  out_last_q;

  logic                  ready_a, ready_b, ready_c;

  assign ready_c     = !out_valid_q || !out_stall_i;
  assign ready_b     = !b_valid_q || ready_c;
  assign ready_a     = !a_valid_q || ready_b;
  assign win_ready_o = ready_a;

  // Sort each triple of the window.
  always_comb begin
    for (int t = 0; t < 3; t++) begin
      a_lo_d[t] = mf3_pkg::pix_min(mf3_pkg::pix_min(win_i.pix[3*t], win_i.pix[3*t+1]),
                                   win_i.pix[3*t+2]);
      a_hi_d[t] = mf3_pkg::pix_max(mf3_pkg::pix_max(win_i.pix[3*t], win_i.pix[3*t+1]),
                                   win_i.pix[3*t+2]);
      a_md_d[t] = mf3_pkg::med3(win_i.pix[3*t], win_i.pix[3*t+1], win_i.pix[3*t+2]);
    end
  end

  // Stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ready_a) begin
        a_valid_q <= win_valid_i;
      end
      if (ready_b) begin
        b_valid_q <= a_valid_q;
      end
      if (ready_c) begin
        out_valid_q <= b_valid_q;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (ready_a && win_valid_i) begin
      a_lo_q   <= a_lo_d;
      a_md_q   <= a_md_d;
      a_hi_q   <= a_hi_d;
      a_last_q <= win_i.last;
    end
    if (ready_b && a_valid_q) begin
      b_lo_q   <= mf3_pkg::pix_max(mf3_pkg::pix_max(a_lo_q[0], a_lo_q[1]), a_lo_q[2]);
      b_md_q   <= mf3_pkg::med3(a_md_q[0], a_md_q[1], a_md_q[2]);
      b_hi_q   <= mf3_pkg::pix_min(mf3_pkg::pix_min(a_hi_q[0], a_hi_q[1]), a_hi_q[2]);
      b_last_q <= a_last_q;
    end
    if (ready_c && b_valid_q) begin
      out_med_q  <= mf3_pkg::med3(b_lo_q, b_md_q, b_hi_q);
      out_last_q <= b_last_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign median_value_o  = out_med_q;
  assign last_of_frame_o = out_last_q;

endmodule

// ----- sim/median_filter_3x3_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the median_filter_3x3 top level.
// Depends on mf3_pkg and the filter RTL. Each median word is checked against a
// behavioral prediction while the input idles and the output stalls at random.
module median_filter_3x3_tb;

  localparam int unsigned ClkHalf      = 6;
  localparam int unsigned ResetCycles  = 5;
  localparam int unsigned DrainCycles  = 8;
  localparam int unsigned CycleLimit   = 2_000_000;
  localparam int unsigned RandomPixels = 290;
  localparam int unsigned MaxReported  = 10;

  // How the pixel values of a frame are drawn.
  typedef enum int unsigned {
    PIX_UNIFORM,
    PIX_NARROW,
    PIX_EXTREME
  } pixel_mix_e;

  // One output word as the filter should deliver it.
  typedef struct packed {
    mf3_pkg::pixel_t median;
    logic            last;
  } median_word_t;

  // Block ports, all inputs known from time zero.
  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  mf3_pkg::pixel_t          pixel_i     = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  mf3_pkg::pixel_t          median_value_o;
  logic                     last_of_frame_o;
  logic                     cfg_we_i    = 1'b0;
  mf3_pkg::cfg_idx_e        cfg_index_i = mf3_pkg::CFG_WIDTH;
  logic [mf3_pkg::CfgW-1:0] cfg_data_i  = '0;

  median_filter_3x3 i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .pixel_i         (pixel_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .median_value_o  (median_value_o),
    .last_of_frame_o (last_of_frame_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // Predicted filter state: line stores, window, raster position, registers.
  mf3_pkg::pixel_t          upper_row  [mf3_pkg::MaxWidth];
  mf3_pkg::pixel_t          middle_row [mf3_pkg::MaxWidth];
  mf3_pkg::pixel_t          prev_cols  [6];
  int unsigned              pred_col   = 0;
  int unsigned              pred_row   = 0;
  logic [mf3_pkg::CfgW-1:0] width_reg  = mf3_pkg::WidthReset;
  logic [mf3_pkg::CfgW-1:0] height_reg = mf3_pkg::HeightReset;
  median_word_t             pending_medians [$];

  int unsigned mismatches  = 0;
  int unsigned pixels_sent = 0;
  int unsigned burst_left  = 0;
  int unsigned cycle_count = 0;

  // Receiver stall pattern state.
  int unsigned stall_style = 0;
  int unsigned style_left  = 0;

  initial begin : clock_gen
    forever #ClkHalf clk_i = ~clk_i;
  end

  // Row width as the block uses it.
  function automatic int unsigned active_width(logic [mf3_pkg::CfgW-1:0] w);
    if (w < mf3_pkg::MinDim) return 32'(mf3_pkg::MinDim);
    if (w > mf3_pkg::MaxDim) return 32'(mf3_pkg::MaxDim);
    return 32'(w);
  endfunction

  // Frame height as the block uses it.
  function automatic int unsigned active_height(logic [mf3_pkg::CfgW-1:0] h);
    return (h < mf3_pkg::MinDim) ? 32'(mf3_pkg::MinDim) : 32'(h);
  endfunction

  // Fifth smallest of the nine neighborhood values.
  function automatic mf3_pkg::pixel_t hood_median(mf3_pkg::pixel_t [8:0] hood);
    mf3_pkg::pixel_t [8:0] s;
    mf3_pkg::pixel_t       t;
    s = hood;
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 8 - i; j++) begin
        if (s[j] > s[j+1]) begin
          t      = s[j];
          s[j]   = s[j+1];
          s[j+1] = t;
        end
      end
    end
    return s[4];
  endfunction

  // Moves the predicted filter by one accepted pixel and queues its word.
  function automatic void advance_filter(mf3_pkg::pixel_t pix);
    int unsigned           w;
    int unsigned           h;
    int unsigned           col;
    mf3_pkg::pixel_t       top;
    mf3_pkg::pixel_t       mid;
    mf3_pkg::pixel_t [8:0] hood;
    logic                  row_end;
    logic                  frame_end;
    median_word_t          word;
    w   = active_width(width_reg);
    h   = active_height(height_reg);
    col = (pred_col >= mf3_pkg::MaxWidth) ? mf3_pkg::MaxWidth - 1 : pred_col;
    top = upper_row[col];
    mid = middle_row[col];
    upper_row[col]  = mid;
    middle_row[col] = pix;
    row_end   = (col + 1 >= w);
    frame_end = row_end && (pred_row + 1 >= h);
    if (pred_row >= mf3_pkg::FirstInnerRow && col >= mf3_pkg::FirstInnerCol) begin
      hood = {prev_cols[0], prev_cols[1], prev_cols[2], prev_cols[3], prev_cols[4],
              prev_cols[5], top, mid, pix};
      word.median = hood_median(hood);
      word.last   = frame_end;
      pending_medians.push_back(word);
    end
    // The oldest column drops out, the current one comes in.
    for (int i = 0; i < 3; i++) prev_cols[i] = prev_cols[i+3];
    prev_cols[3] = top;
    prev_cols[4] = mid;
    prev_cols[5] = pix;
    if (row_end) begin
      pred_col = 0;
      pred_row = frame_end ? 0 : ((pred_row + 1) & 32'hFFF);
    end else begin
      pred_col = col + 1;
    end
  endfunction

  function automatic mf3_pkg::pixel_t pick_pixel(pixel_mix_e mix, mf3_pkg::pixel_t base);
    case (mix)
      PIX_NARROW:  return base + mf3_pkg::pixel_t'($urandom_range(0, 3));
      PIX_EXTREME: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      default:     return mf3_pkg::pixel_t'($urandom_range(0, 255));
    endcase
  endfunction

  // Sends one word in bursts of random length separated by random gaps.
  task automatic send_pixel(mf3_pkg::pixel_t pix);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    pixel_i    <= pix;
    do @(posedge clk_i); while (in_stall_o);
    advance_filter(pix);
    pixels_sent++;
  endtask

  task automatic send_pixels(int unsigned count, pixel_mix_e mix);
    mf3_pkg::pixel_t base;
    base = mf3_pkg::pixel_t'($urandom_range(0, 255));
    repeat (count) send_pixel(pick_pixel(mix, base));
  endtask

  // Drops valid and waits until every queued word has come out, plus a margin
  // for pixels that are still in flight without a word of their own.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_medians.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(mf3_pkg::cfg_idx_e idx, logic [mf3_pkg::CfgW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    if (idx == mf3_pkg::CFG_WIDTH) width_reg = value;
    else height_reg = value;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_frame_size(logic [mf3_pkg::CfgW-1:0] w,
                                logic [mf3_pkg::CfgW-1:0] h);
    write_reg(mf3_pkg::CFG_WIDTH, w);
    write_reg(mf3_pkg::CFG_HEIGHT, h);
  endtask

  // One full row at the reset width, then the rows are narrowed and the
  // height is lowered so the frame ends on its third row.
  task automatic test_reset_geometry();
    send_pixels(active_width(mf3_pkg::WidthReset), PIX_UNIFORM);
    wait_idle();
    write_reg(mf3_pkg::CFG_WIDTH, mf3_pkg::MinDim);
    send_pixels(active_width(mf3_pkg::MinDim), PIX_UNIFORM);
    wait_idle();
    write_reg(mf3_pkg::CFG_HEIGHT, mf3_pkg::MinDim);
    send_pixels(active_width(mf3_pkg::MinDim), PIX_EXTREME);
    wait_idle();
  endtask

  // Smallest frames, with sizes below the legal range acting as three.
  task automatic test_border_cases();
    mf3_pkg::pixel_t [8:0] distinct_px = {8'd200, 8'd7, 8'd90, 8'd255, 8'd0, 8'd128,
                                          8'd64, 8'd33, 8'd1};
    mf3_pkg::pixel_t [8:0] mixed_px    = {8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255,
                                          8'd0, 8'd255, 8'd128};
    set_frame_size('0, '0);
    repeat (9) send_pixel(8'hFF);
    wait_idle();
    set_frame_size(mf3_pkg::CfgW'(2), mf3_pkg::CfgW'(2));
    for (int i = 8; i >= 0; i--) send_pixel(distinct_px[i]);
    wait_idle();
    set_frame_size(mf3_pkg::MinDim, mf3_pkg::MinDim);
    for (int i = 8; i >= 0; i--) send_pixel(mixed_px[i]);
    wait_idle();
  endtask

  // Width and height lowered in the middle of a frame: the counters are kept
  // and the row and the frame end at the first position at or past the limit.
  task automatic test_mid_frame_writes();
    set_frame_size(mf3_pkg::CfgW'(8), mf3_pkg::CfgW'(6));
    send_pixels(3 * 8 + 5, PIX_UNIFORM);
    wait_idle();
    write_reg(mf3_pkg::CFG_WIDTH, mf3_pkg::MinDim);
    send_pixels(1, PIX_UNIFORM);
    send_pixels(2, PIX_UNIFORM);
    wait_idle();
    write_reg(mf3_pkg::CFG_HEIGHT, mf3_pkg::CfgW'(4));
    send_pixels(1, PIX_UNIFORM);
    wait_idle();
  endtask

  // Random small frames, often back to back with the same size.
  task automatic test_random_frames();
    int unsigned              first;
    logic [mf3_pkg::CfgW-1:0] w_val;
    logic [mf3_pkg::CfgW-1:0] h_val;
    first = pixels_sent;
    while (pixels_sent - first < RandomPixels) begin
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 9))
          0:       w_val = mf3_pkg::CfgW'($urandom_range(0, 2));
          1:       w_val = mf3_pkg::CfgW'($urandom_range(13, 48));
          default: w_val = mf3_pkg::CfgW'($urandom_range(3, 12));
        endcase
        if ($urandom_range(0, 7) == 0) h_val = mf3_pkg::CfgW'($urandom_range(0, 2));
        else h_val = mf3_pkg::CfgW'($urandom_range(3, 6));
        wait_idle();
        set_frame_size(w_val, h_val);
      end
      send_pixels(active_width(width_reg) * active_height(height_reg),
                  pixel_mix_e'($urandom_range(0, 2)));
    end
    wait_idle();
  endtask

  // All-ones width, clamped to the line store depth: the first row is ended
  // early by a width write, then the frame finishes with narrow rows.
  task automatic test_widest_frame();
    set_frame_size('1, mf3_pkg::MinDim);
    send_pixels(24, PIX_UNIFORM);
    wait_idle();
    write_reg(mf3_pkg::CFG_WIDTH, mf3_pkg::MinDim);
    send_pixels(1 + 2 * active_width(mf3_pkg::MinDim), PIX_UNIFORM);
    wait_idle();
  endtask

  // All-ones height with the narrowest rows, ended early by a height write.
  task automatic test_tallest_frame();
    set_frame_size(mf3_pkg::MinDim, '1);
    send_pixels(3 * 8, PIX_UNIFORM);
    wait_idle();
    write_reg(mf3_pkg::CFG_HEIGHT, mf3_pkg::MinDim);
    send_pixels(active_width(mf3_pkg::MinDim), PIX_UNIFORM);
    wait_idle();
  endtask

  initial begin : stimulus
    foreach (upper_row[i]) begin
      upper_row[i]  = '0;
      middle_row[i] = '0;
    end
    foreach (prev_cols[i]) prev_cols[i] = '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_geometry();
    test_border_cases();
    test_mid_frame_writes();
    test_random_frames();
    test_widest_frame();
    test_tallest_frame();
    wait_idle();
    if (mismatches == 0 && pending_medians.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Receiver stall pattern: free running, random, mostly stalled, or toggling,
  // each style held for a random stretch.
  always @(posedge clk_i) begin
    if (style_left == 0) begin
      stall_style <= $urandom_range(0, 3);
      style_left  <= $urandom_range(50, 300);
    end else begin
      style_left <= style_left - 1;
    end
    case (stall_style)
      1:       out_stall_i <= ($urandom_range(0, 2) == 0);
      2:       out_stall_i <= ($urandom_range(0, 9) < 8);
      3:       out_stall_i <= ~out_stall_i;
      default: out_stall_i <= 1'b0;
    endcase
  end

  // Each accepted word is compared with the oldest queued prediction.
  always @(posedge clk_i) begin : check_words
    median_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_medians.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReported)
          $display("unexpected word: median %0d last %0b", median_value_o,
                   last_of_frame_o);
      end else begin
        want = pending_medians.pop_front();
        if (median_value_o !== want.median || last_of_frame_o !== want.last) begin
          mismatches++;
          if (mismatches <= MaxReported)
            $display("mismatch: expected median %0d last %0b, got median %0d last %0b",
                     want.median, want.last, median_value_o, last_of_frame_o);
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
